/* rtl/core/integer_square_root_u64_assert.svh */
// Assertion macros for the integer square root block.
`ifndef INTEGER_SQUARE_ROOT_U64_ASSERT_SVH
`define INTEGER_SQUARE_ROOT_U64_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ISR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ISR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ISR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ISR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/isr_pkg.sv */
// Types, constants and the control program of the integer square root block.
`timescale 1ns / 1ps
package isr_pkg;
	localparam int OP_W   = 64;
	localparam int ROOT_W = 32;
	// The remainder stays at most twice the partial root, so after the two-bit shift
	// it fits in root width plus three.
	localparam int REM_W  = ROOT_W + 3;
	localparam int CNT_W  = $clog2(ROOT_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

	typedef logic [1:0] step_t;
	localparam step_t STEP_WAIT = 2'd0;
	localparam step_t STEP_ITER = 2'd1;
	localparam step_t STEP_EMIT = 2'd2;

	// Jump conditions; when the condition is false the sequencer holds its step.
	typedef enum logic [1:0] {
		COND_ALWAYS   = 2'd0,
		COND_IN_BEAT  = 2'd1,
		COND_CNT_LAST = 2'd2,
		COND_OUT_FREE = 2'd3
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  load;
		logic  iter;
		logic  emit;
		cond_t cond;
		step_t target;
	} uword_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic iter;
	} dp_cmd_t;

	// Control store: one word per step.
	function automatic uword_t ucode_rom(input step_t addr);
		uword_t w;
		w = '{in_ready: 1'b0, load: 1'b0, iter: 1'b0, emit: 1'b0,
			cond: COND_ALWAYS, target: STEP_WAIT};
		unique case (addr)
			STEP_WAIT: begin
				w.in_ready = 1'b1;
				w.load     = 1'b1;
				w.cond     = COND_IN_BEAT;
				w.target   = STEP_ITER;
			end
			STEP_ITER: begin
				w.iter   = 1'b1;
				w.cond   = COND_CNT_LAST;
				w.target = STEP_EMIT;
			end
			STEP_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = COND_OUT_FREE;
				w.target = STEP_WAIT;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction
endpackage

/* rtl/core/isr_operand_if.sv */
// Input channel carrying the 64-bit operand.
`timescale 1ns / 1ps
interface isr_operand_if;
	logic                      valid;
	logic                      ready;
	logic [isr_pkg::OP_W-1:0] operand;

	modport source (output valid, output operand, input ready);
	modport sink (input valid, input operand, output ready);
endinterface

/* rtl/core/isr_root_if.sv */
// Output channel carrying the 32-bit root.
`timescale 1ns / 1ps
interface isr_root_if;
	logic                        valid;
	logic                        ready;
	logic [isr_pkg::ROOT_W-1:0] root;

	modport source (output valid, output root, input ready);
	modport sink (input valid, input root, output ready);
endinterface

/* rtl/core/isr_datapath.sv */
// Restoring square root datapath: one compare and subtract per step.
`timescale 1ns / 1ps
module isr_datapath (
	input  logic                        clk,
	input  isr_pkg::dp_cmd_t            cmd,
	input  logic [isr_pkg::OP_W-1:0]   operand,
	output logic [isr_pkg::ROOT_W-1:0] root
);
	import isr_pkg::*;

	logic [OP_W-1:0]   op_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] acc_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	// Bring down the next two operand bits and form the trial value 4*acc+1.
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], op_q[OP_W-1 -: 2]};
		trial  = {1'b0, acc_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	// Operand shifter, partial remainder and root accumulator.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operand;
			rem_q <= '0;
			acc_q <= '0;
		end else if (cmd.iter) begin
			op_q  <= {op_q[OP_W-3:0], 2'b00};
			rem_q <= fits ? (rem_sh - trial) : rem_sh;
			acc_q <= {acc_q[ROOT_W-2:0], fits};
		end
	end

	assign root = acc_q;
endmodule

/* rtl/core/integer_square_root_u64.sv */
// Integer square root of a 64-bit operand, one result bit per cycle.
// The wait step loads the operand, the iteration step makes one pass per
// root bit through the shared compare-subtract unit and the output step
// loads the output register once free; only the wait step takes operands.
// Reset clears the sequencer, the step counter and the output valid flag.
`timescale 1ns / 1ps
`include "integer_square_root_u64_assert.svh"
module integer_square_root_u64 (
	input  logic          clk,
	input  logic          arst_n,
	isr_operand_if.sink   in_ch,
	isr_root_if.source    out_ch
);
	import isr_pkg::*;

	step_t             step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [ROOT_W-1:0] root_q;
	uword_t            uw;
	dp_cmd_t           cmd;
	logic              cond_ok;
	logic              out_free;
	logic [ROOT_W-1:0] dp_root;

	// Fetch the control word for the current step.
	assign uw       = ucode_rom(step_q);
	assign out_free = !out_valid_q || out_ch.ready;

	always_comb begin
		unique case (uw.cond)
			COND_ALWAYS:   cond_ok = 1'b1;
			COND_IN_BEAT:  cond_ok = in_ch.valid;
			COND_CNT_LAST: cond_ok = cnt_q == CNT_LAST;
			COND_OUT_FREE: cond_ok = out_free;
			default:       cond_ok = 1'b0;
		endcase
	end

	assign in_ch.ready = uw.in_ready;
	assign cmd.load    = uw.load && in_ch.valid;
	assign cmd.iter    = uw.iter;

	// Step register and iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
			cnt_q  <= '0;
		end else begin
			if (cond_ok) begin
				step_q <= uw.target;
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.iter) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	isr_datapath u_datapath (
		.clk     (clk),
		.cmd     (cmd),
		.operand (in_ch.operand),
		.root    (dp_root)
	);

	// Output register; it holds a finished root until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.emit && out_free) begin
			root_q <= dp_root;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.root  = root_q;

	// Sequencer checks.
	`ISR_ASSERT_NEXT(a_beat_starts_iter, clk, arst_n, in_ch.valid && in_ch.ready,
		step_q == STEP_ITER && cnt_q == '0, "accepted beat did not start the iterations")
	`ISR_ASSERT_SAME(a_busy_not_ready, clk, arst_n, step_q != STEP_WAIT, !in_ch.ready,
		"input ready while an operand is in work")
	`ISR_ASSERT_SAME(a_idle_count_clear, clk, arst_n, step_q != STEP_ITER, cnt_q == '0,
		"iteration count not clear outside the iteration step")
	`ISR_ASSERT_NEXT(a_emit_loads_out, clk, arst_n, step_q == STEP_EMIT && out_free,
		out_ch.valid && step_q == STEP_WAIT, "finished root was not presented")
endmodule
